/* design/fca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, codes and constants of the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int IDX_W = 11;
    localparam int CNT_W = 12;
    localparam int ENT_W = 15;
    // position width: holds any index, link value or table length
    localparam int CW    = 16;

    localparam int TABLE_DEPTH_DEF  = 2048;
    localparam int FAT_RESERVED_DEF = 4;
    localparam int ROOT_INDEX_DEF   = 4;

    localparam logic [ENT_W-1:0] ENT_FREE = 15'h0000;
    localparam logic [ENT_W-1:0] ENT_RSV  = 15'h7ffe;
    localparam logic [ENT_W-1:0] ENT_END  = 15'h7fff;

    typedef enum logic [2:0] {
        REQ_ALLOC  = 3'd0,
        REQ_FREE   = 3'd1,
        REQ_TAIL   = 3'd2,
        REQ_SET    = 3'd3,
        REQ_READ   = 3'd4,
        REQ_FORMAT = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CNT,
        S_LINK,
        S_AEND,
        S_WALK,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic is_free;
        logic is_rsv;
        logic is_end;
        logic is_link_bad;
    } t_ent_class;

endpackage

/* design/fca_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_table
// Link table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fca_table import fca_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ENT_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [ENT_W-1:0] o_rdata
);

    logic [ENT_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fca_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_classify
// Shared entry compare unit: sorts one table entry into free, reserved,
// chain end or out-of-range link.
// ----------------------------------------------------------------------------
module fca_classify import fca_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic [ENT_W-1:0] i_entry,
    output t_ent_class       o_class
);

    localparam logic [CW-1:0] NB = CW'(TABLE_DEPTH);

    always_comb begin
        o_class.is_free     = (i_entry == ENT_FREE);
        o_class.is_rsv      = (i_entry == ENT_RSV);
        o_class.is_end      = (i_entry == ENT_END);
        o_class.is_link_bad = ({1'b0, i_entry} >= NB) && (i_entry != ENT_END);
    end

endmodule

/* design/fat_chain_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table of 15-bit links with allocate, free, tail, set,
// read and format requests, run by a sequencer over one table read port.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_valid / o_stall carries one request (type, block index,
//   block count, link value); output channel o_valid / i_stall returns one
//   result (status, result block, entry value) per request.
//   One request is worked at a time; o_stall is high while it runs.
//   Run time per request is set by the single table read port visiting one
//   entry per cycle: allocate scans the table in up to two passes (count,
//   then link) and stops early on success; find tail walks the chain once;
//   free walks it twice (check, then clear); format clears every entry;
//   set link, bad index and unknown type go straight to the result state,
//   and read entry passes through one read state first.
//   After reset the table is formatted by a clearing pass over every entry;
//   o_stall stays high during it.
//   A finished result sits in an output register; a new request is accepted
//   while it waits, and the next result is held back until it is taken.
// ----------------------------------------------------------------------------
module fat_chain_allocator import fca_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int FAT_RESERVED = FAT_RESERVED_DEF,
    parameter int ROOT_INDEX   = ROOT_INDEX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_req_type,
    input  logic [IDX_W-1:0] i_block_index,
    input  logic [CNT_W-1:0] i_block_count,
    input  logic [ENT_W-1:0] i_link_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_result_block,
    output logic [ENT_W-1:0] o_entry_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] NB        = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ROOT      = CW'(ROOT_INDEX);
    localparam logic [CW-1:0] ROOT_NEXT = CW'(ROOT_INDEX + 1);
    localparam logic [CW-1:0] RSV_TOP   = CW'(FAT_RESERVED);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_start, n_start;
    logic [CW-1:0]    r_last, n_last;
    logic [CW-1:0]    r_first, n_first;
    logic [CW-1:0]    r_steps, n_steps;
    logic             r_chk, n_chk;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_avail, n_avail;
    t_req             r_req, n_req;
    logic             r_fmt_resp, n_fmt_resp;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_blk, n_res_blk;
    logic [ENT_W-1:0] r_res_val, n_res_val;
    logic             r_o_valid, n_o_valid;
    t_status          r_o_status, n_o_status;
    logic [IDX_W-1:0] r_o_blk, n_o_blk;
    logic [ENT_W-1:0] r_o_val, n_o_val;

    logic             mem_we;
    logic [CW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [CW-1:0]    rd_addr;
    logic [ENT_W-1:0] rdata;
    t_ent_class       cls;

    logic             hit;
    logic             idx_ok;
    logic             out_free;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    idx_w;

    fca_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    fca_classify #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_classify (
        .i_entry (rdata),
        .o_class (cls)
    );

    assign idx_w    = {{(CW-IDX_W){1'b0}}, i_block_index};
    assign idx_ok   = (idx_w < NB);
    assign hit      = r_chk && cls.is_free;
    // entry whose data is arriving during a scan
    assign pos      = r_addr - CW'(1);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_start      = r_start;
        n_last       = r_last;
        n_first      = r_first;
        n_steps      = r_steps;
        n_chk        = r_chk;
        n_cnt        = r_cnt;
        n_avail      = r_avail;
        n_req        = r_req;
        n_fmt_resp   = r_fmt_resp;
        n_res_status = r_res_status;
        n_res_blk    = r_res_blk;
        n_res_val    = r_res_val;
        n_o_valid    = r_o_valid && i_stall;
        n_o_status   = r_o_status;
        n_o_blk      = r_o_blk;
        n_o_val      = r_o_val;
        mem_we       = 1'b0;
        mem_waddr    = r_addr;
        mem_wdata    = ENT_FREE;
        rd_addr      = r_addr;
        o_stall      = (r_state != S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == ROOT) begin
                    mem_wdata = ENT_END;
                end else if (r_addr < RSV_TOP) begin
                    mem_wdata = ENT_RSV;
                end else begin
                    mem_wdata = ENT_FREE;
                end
                if (r_addr == NB - CW'(1)) begin
                    n_state = r_fmt_resp ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end

            S_IDLE: begin
                rd_addr = idx_w;
                if (i_valid) begin
                    n_req        = t_req'(i_req_type);
                    n_res_status = ST_OK;
                    n_res_blk    = '0;
                    n_res_val    = '0;
                    n_state      = S_DONE;
                    unique case (t_req'(i_req_type))
                        REQ_ALLOC: begin
                            if (i_block_count == '0) begin
                                n_res_status = ST_BAD;
                            end else begin
                                n_state = S_CNT;
                                n_addr  = ROOT_NEXT;
                                n_chk   = 1'b0;
                                n_avail = '0;
                                n_cnt   = i_block_count;
                            end
                        end
                        REQ_FREE, REQ_TAIL: begin
                            if (!idx_ok) begin
                                n_res_status = ST_BAD;
                            end else begin
                                n_state = S_WALK;
                                n_addr  = idx_w;
                                n_start = idx_w;
                                n_steps = '0;
                            end
                        end
                        REQ_SET: begin
                            if (!idx_ok) begin
                                n_res_status = ST_BAD;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_w;
                                mem_wdata = i_link_value;
                            end
                        end
                        REQ_READ: begin
                            if (!idx_ok) begin
                                n_res_status = ST_BAD;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        REQ_FORMAT: begin
                            n_state    = S_CLEAR;
                            n_addr     = '0;
                            n_fmt_resp = 1'b1;
                        end
                        default: begin
                            n_res_status = ST_BAD;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_res_val = rdata;
                n_state   = S_DONE;
            end

            // first pass: count free entries, table untouched
            S_CNT: begin
                if (hit && (r_avail + CNT_W'(1) == r_cnt)) begin
                    n_state = S_LINK;
                    n_addr  = ROOT_NEXT;
                    n_chk   = 1'b0;
                    n_avail = '0;
                end else if (r_addr >= NB) begin
                    n_res_status = ST_NOSPACE;
                    n_state      = S_DONE;
                end else begin
                    n_addr  = r_addr + CW'(1);
                    n_chk   = 1'b1;
                    n_avail = r_avail + CNT_W'(hit);
                end
            end

            // second pass: link the free entries in order
            S_LINK: begin
                n_addr = r_addr + CW'(1);
                n_chk  = 1'b1;
                if (hit) begin
                    if (r_avail == '0) begin
                        n_first = pos;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_last;
                        mem_wdata = pos[ENT_W-1:0];
                    end
                    n_last  = pos;
                    n_avail = r_avail + CNT_W'(1);
                    if (r_avail + CNT_W'(1) == r_cnt) begin
                        n_state = S_AEND;
                    end
                end
            end

            S_AEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_last;
                mem_wdata = ENT_END;
                n_res_blk = r_first[IDX_W-1:0];
                n_state   = S_DONE;
            end

            // chain check, one link per cycle
            S_WALK: begin
                if (cls.is_free || cls.is_rsv) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else if (cls.is_end) begin
                    if (r_req == REQ_FREE) begin
                        n_state = S_FREE;
                        n_addr  = r_start;
                        rd_addr = r_start;
                    end else begin
                        n_res_blk = r_addr[IDX_W-1:0];
                        n_state   = S_DONE;
                    end
                end else if (cls.is_link_bad || (r_steps == NB - CW'(1))) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else begin
                    n_addr  = {1'b0, rdata};
                    rd_addr = {1'b0, rdata};
                    n_steps = r_steps + CW'(1);
                end
            end

            // chain already checked: clear while following it
            S_FREE: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = ENT_FREE;
                if (cls.is_end) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = {1'b0, rdata};
                    rd_addr = {1'b0, rdata};
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_blk    = r_res_blk;
                    n_o_val    = r_res_val;
                    n_fmt_resp = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_fmt_resp <= 1'b0;
            r_o_valid  <= 1'b0;
            r_chk      <= 1'b0;
            r_avail    <= '0;
            r_cnt      <= '0;
            r_steps    <= '0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_fmt_resp <= n_fmt_resp;
            r_o_valid  <= n_o_valid;
            r_chk      <= n_chk;
            r_avail    <= n_avail;
            r_cnt      <= n_cnt;
            r_steps    <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_last       <= n_last;
        r_first      <= n_first;
        r_req        <= n_req;
        r_res_status <= n_res_status;
        r_res_blk    <= n_res_blk;
        r_res_val    <= n_res_val;
        r_o_status   <= n_o_status;
        r_o_blk      <= n_o_blk;
        r_o_val      <= n_o_val;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_block = r_o_blk;
    assign o_entry_value  = r_o_val;

    a_cnt_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT) |-> (r_avail < r_cnt))
        else $error("free count passed the request count");

    a_link_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_avail < r_cnt))
        else $error("linked more blocks than requested");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps < NB))
        else $error("chain walk ran past the table length");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_IDLE)) |-> (i_valid && (i_req_type == REQ_SET)))
        else $error("table written with no set link request");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (o_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");

endmodule
